// ===== design/nsol_pkg.sv =====
// shared constants, types and helpers of the screlu output layer
package nsol_pkg;

   localparam int VAL_W   = 16;
   localparam int SUM_W   = 32;
   localparam int SCORE_W = 18;
   localparam int CLAMP_W = 7;
   localparam int RSUM_W  = 25;
   localparam int MAG_W   = 32;
   localparam int Q1_W    = 26;
   localparam int UNSQ_W  = 27;
   localparam int PROD_W  = 64;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam int QA        = 101;
   localparam int QB        = 160;
   localparam int SCALE     = 340;
   localparam int DIV2      = QA * QB;
   localparam int SCORE_MAX = 88937;

   // 340 / 16160 reduces to 17 / 808, and 808 is 8 * 101
   localparam int SCALE_RED  = SCALE / 20;
   localparam int DIV2_SHIFT = 3;

   // ceil(2^38 / 101), exact for every dividend up to 2^31
   localparam logic [MAG_W-1:0] RECIP_QA    = 32'd2721563436;
   localparam int               RECIP_SHIFT = 38;

   localparam logic [0:0] REG_OUTPUT_BIAS = 1'b0;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV1,
      BK_BIAS,
      BK_MUL,
      BK_DIV2,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [CLAMP_W-1:0] clamp_qa(input logic signed [VAL_W-1:0] v);
      if (v[VAL_W-1]) begin
         return '0;
      end else if (v > VAL_W'(QA)) begin
         return CLAMP_W'(QA);
      end else begin
         return v[CLAMP_W-1:0];
      end
   endfunction

endpackage

// ===== design/nsol_front.sv =====
// front pipeline: clamp, two multiply stages and the running sum
module nsol_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic signed [nsol_pkg::VAL_W-1:0]  white_value,
   input  logic signed [nsol_pkg::VAL_W-1:0]  black_value,
   input  logic                               side_to_move,
   input  logic signed [nsol_pkg::VAL_W-1:0]  mover_weight,
   input  logic signed [nsol_pkg::VAL_W-1:0]  other_weight,
   input  logic                               last,
   input  nsol_pkg::queue_status_type         q_status,
   output logic                               q_push,
   output logic [nsol_pkg::SUM_W-1:0]         q_data
);

   logic                                  stall;
   logic                                  accept;
   logic signed [nsol_pkg::VAL_W-1:0]     mover;
   logic signed [nsol_pkg::VAL_W-1:0]     other;
   logic [nsol_pkg::CLAMP_W-1:0]          cm;
   logic [nsol_pkg::CLAMP_W-1:0]          co;
   logic signed [23:0]                    pm;
   logic signed [23:0]                    po;
   logic signed [23:0]                    rm;
   logic signed [23:0]                    ro;
   logic [nsol_pkg::SUM_W-1:0]            total;

   logic                                  s1_valid_ff, s1_valid_in;
   logic                                  s1_last_ff;
   logic [nsol_pkg::CLAMP_W-1:0]          s1_cm_ff, s1_co_ff;
   logic signed [nsol_pkg::VAL_W-1:0]     s1_tm_ff, s1_to_ff;
   logic                                  s2_valid_ff, s2_valid_in;
   logic                                  s2_last_ff;
   logic signed [nsol_pkg::RSUM_W-1:0]    s2_rsum_ff, s2_rsum_in;
   logic [nsol_pkg::SUM_W-1:0]            sum_ff, sum_in;

   // a last transaction cannot leave the pipe while the sum queue is full
   assign stall  = s2_valid_ff && s2_last_ff && q_status.full;
   assign full   = stall;
   assign accept = push && !stall;

   assign mover = side_to_move ? black_value : white_value;
   assign other = side_to_move ? white_value : black_value;
   assign cm    = nsol_pkg::clamp_qa(mover);
   assign co    = nsol_pkg::clamp_qa(other);
   assign pm    = $signed({1'b0, cm}) * mover_weight;
   assign po    = $signed({1'b0, co}) * other_weight;

   assign rm         = s1_tm_ff * $signed({1'b0, s1_cm_ff});
   assign ro         = s1_to_ff * $signed({1'b0, s1_co_ff});
   assign s2_rsum_in = nsol_pkg::RSUM_W'(rm) + nsol_pkg::RSUM_W'(ro);

   assign total = sum_ff + nsol_pkg::SUM_W'(s2_rsum_ff);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      sum_in      = sum_ff;
      q_push      = 1'b0;
      if (!stall) begin
         s1_valid_in = accept;
         s2_valid_in = s1_valid_ff;
         if (s2_valid_ff) begin
            if (s2_last_ff) begin
               q_push = 1'b1;
               sum_in = '0;
            end else begin
               sum_in = total;
            end
         end
      end
   end

   assign q_data = total;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         sum_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         sum_ff      <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_last_ff <= last;
         s1_cm_ff   <= cm;
         s1_co_ff   <= co;
         s1_tm_ff   <= pm[nsol_pkg::VAL_W-1:0];
         s1_to_ff   <= po[nsol_pkg::VAL_W-1:0];
         s2_last_ff <= s1_last_ff;
         s2_rsum_ff <= s2_rsum_in;
      end
   end

endmodule

// ===== design/nsol_queue.sv =====
// two-entry queue of finished sums between front and back
module nsol_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [nsol_pkg::SUM_W-1:0]    wdata,
   input  logic                          pop,
   output nsol_pkg::queue_status_type    status,
   output logic [nsol_pkg::SUM_W-1:0]    rdata
);

   logic [nsol_pkg::SUM_W-1:0] mem_ff [2];
   logic                       wr_ptr_ff, wr_ptr_in;
   logic                       rd_ptr_ff, rd_ptr_in;
   logic [1:0]                 count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign rdata        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== design/nsol_back.sv =====
// back end: two divisions by reciprocal multiplication, bias, scale and clip
module nsol_back (
   input  logic                               clock,
   input  logic                               reset,
   input  nsol_pkg::queue_status_type         q_status,
   input  logic [nsol_pkg::SUM_W-1:0]         q_data,
   output logic                               q_pop,
   input  logic signed [nsol_pkg::VAL_W-1:0]  output_bias,
   input  logic                               pop,
   output logic                               empty,
   output logic signed [nsol_pkg::SCORE_W-1:0] score
);

   nsol_pkg::back_state_type               state_ff, state_in;
   logic                                   sign_ff, sign_in;
   logic [nsol_pkg::MAG_W-1:0]             mag_ff, mag_in;
   logic [nsol_pkg::PROD_W-1:0]            prod_ff, prod_in;
   logic signed [nsol_pkg::UNSQ_W-1:0]     unsq_ff, unsq_in;
   logic                                   out_valid_ff, out_valid_in;
   logic signed [nsol_pkg::SCORE_W-1:0]    score_ff, score_in;

   logic [nsol_pkg::Q1_W-1:0]              quot;
   logic signed [nsol_pkg::UNSQ_W-1:0]     q1_signed;
   logic [nsol_pkg::UNSQ_W-1:0]            unsq_mag;
   logic [nsol_pkg::MAG_W-1:0]             scaled;
   logic [nsol_pkg::SCORE_W-1:0]           sat;

   // quotient by 101 of whatever magnitude was multiplied last
   assign quot      = prod_ff[nsol_pkg::PROD_W-1:nsol_pkg::RECIP_SHIFT];
   assign q1_signed = sign_ff ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
   assign unsq_mag  = unsq_ff[nsol_pkg::UNSQ_W-1] ? nsol_pkg::UNSQ_W'(-unsq_ff)
                                                  : nsol_pkg::UNSQ_W'(unsq_ff);
   assign scaled    = nsol_pkg::MAG_W'(unsq_mag) * nsol_pkg::MAG_W'(nsol_pkg::SCALE_RED);
   assign sat       = (quot > nsol_pkg::Q1_W'(nsol_pkg::SCORE_MAX))
                      ? nsol_pkg::SCORE_W'(nsol_pkg::SCORE_MAX)
                      : quot[nsol_pkg::SCORE_W-1:0];

   always_comb begin
      state_in     = state_ff;
      sign_in      = sign_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      unsq_in      = unsq_ff;
      score_in     = score_ff;
      out_valid_in = out_valid_ff && !pop;
      q_pop        = 1'b0;
      unique case (state_ff)
         nsol_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               sign_in  = q_data[nsol_pkg::SUM_W-1];
               mag_in   = q_data[nsol_pkg::SUM_W-1] ? -q_data : q_data;
               state_in = nsol_pkg::BK_DIV1;
            end
         end
         nsol_pkg::BK_DIV1, nsol_pkg::BK_DIV2: begin
            prod_in  = nsol_pkg::PROD_W'(mag_ff) * nsol_pkg::PROD_W'(nsol_pkg::RECIP_QA);
            state_in = (state_ff == nsol_pkg::BK_DIV1) ? nsol_pkg::BK_BIAS
                                                       : nsol_pkg::BK_DONE;
         end
         nsol_pkg::BK_BIAS: begin
            unsq_in  = q1_signed + nsol_pkg::UNSQ_W'(output_bias);
            state_in = nsol_pkg::BK_MUL;
         end
         nsol_pkg::BK_MUL: begin
            // floor(u * 17 / 808) is floor(floor(u * 17 / 8) / 101)
            sign_in  = unsq_ff[nsol_pkg::UNSQ_W-1];
            mag_in   = scaled >> nsol_pkg::DIV2_SHIFT;
            state_in = nsol_pkg::BK_DIV2;
         end
         nsol_pkg::BK_DONE: begin
            // wait for the output register to free up
            if (!out_valid_ff || pop) begin
               score_in     = sign_ff ? -$signed(sat) : $signed(sat);
               out_valid_in = 1'b1;
               state_in     = nsol_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = nsol_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nsol_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_ff  <= sign_in;
      mag_ff   <= mag_in;
      prod_ff  <= prod_in;
      unsq_ff  <= unsq_in;
      score_ff <= score_in;
   end

   assign empty = !out_valid_ff;
   assign score = score_ff;

endmodule

// ===== design/nnue_screlu_output_layer.sv =====
// top level of the screlu output layer: register port, front, sum queue, back
//
//   channel   direction  handshake             payload
//   request   in         push / full           req_white_value .. req_last
//   response  out        pop / empty           rsp_score
//   csr       in/out     psel penable pwrite   paddr pwdata prdata (output_bias)
//
// the front takes one transaction per cycle while full is low; products pass through
// the s1 and s2 registers before they reach the running sum
// the back end works on one score at a time: a reciprocal multiply for the first
// division, then bias, scale, a reciprocal multiply for the second division and clip;
// a finished score stalls while an earlier score waits
// full rises only while a last transaction meets a full two-entry sum queue
// reset clears the running sum, the queue, the output register and output_bias
module nnue_screlu_output_layer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic signed [nsol_pkg::VAL_W-1:0]    req_white_value,
   input  logic signed [nsol_pkg::VAL_W-1:0]    req_black_value,
   input  logic                                 req_side_to_move,
   input  logic signed [nsol_pkg::VAL_W-1:0]    req_mover_weight,
   input  logic signed [nsol_pkg::VAL_W-1:0]    req_other_weight,
   input  logic                                 req_last,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [nsol_pkg::SCORE_W-1:0]  rsp_score,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [nsol_pkg::ADDR_W-1:0]          paddr,
   input  logic [nsol_pkg::DATA_W-1:0]          pwdata,
   output logic [nsol_pkg::DATA_W-1:0]          prdata,
   output logic                                 pready
);

   logic signed [nsol_pkg::VAL_W-1:0] bias_ff, bias_in;
   logic                              csr_write;
   logic                              q_push;
   logic                              q_pop;
   logic [nsol_pkg::SUM_W-1:0]        q_wdata;
   logic [nsol_pkg::SUM_W-1:0]        q_rdata;
   nsol_pkg::queue_status_type        q_status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[2] == nsol_pkg::REG_OUTPUT_BIAS);
   assign bias_in   = csr_write ? pwdata[nsol_pkg::VAL_W-1:0] : bias_ff;
   assign prdata    = (paddr[2] == nsol_pkg::REG_OUTPUT_BIAS)
                      ? nsol_pkg::DATA_W'(bias_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
      end else begin
         bias_ff <= bias_in;
      end
   end

   nsol_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .white_value  (req_white_value),
      .black_value  (req_black_value),
      .side_to_move (req_side_to_move),
      .mover_weight (req_mover_weight),
      .other_weight (req_other_weight),
      .last         (req_last),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_data       (q_wdata)
   );

   nsol_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .status (q_status),
      .rdata  (q_rdata)
   );

   nsol_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .q_data      (q_rdata),
      .q_pop       (q_pop),
      .output_bias (bias_ff),
      .pop         (pop),
      .empty       (empty),
      .score       (rsp_score)
   );

   // a finished sum is never dropped on a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_status.full)
      else $error("sum pushed into full queue");

   // the back end only takes a sum that is there
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_status.empty)
      else $error("sum popped from empty queue");

   // scores stay within the clip range
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_score <= 18'sd88937 && rsp_score >= -18'sd88937))
      else $error("score outside clip range");

   // a waiting score leaves only when it is taken
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(empty) |-> $past(pop))
      else $error("score lost without pop");

endmodule

// ===== test/nnue_screlu_output_layer_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the screlu output layer, with a score predictor and checker
module nnue_screlu_output_layer_test;

   typedef struct {
      logic signed [nsol_pkg::VAL_W-1:0] white_value;
      logic signed [nsol_pkg::VAL_W-1:0] black_value;
      logic                              side_to_move;
      logic signed [nsol_pkg::VAL_W-1:0] mover_weight;
      logic signed [nsol_pkg::VAL_W-1:0] other_weight;
      logic                              last;
   } acc_index_type;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 push;
   logic                                 full;
   logic signed [nsol_pkg::VAL_W-1:0]    req_white_value;
   logic signed [nsol_pkg::VAL_W-1:0]    req_black_value;
   logic                                 req_side_to_move;
   logic signed [nsol_pkg::VAL_W-1:0]    req_mover_weight;
   logic signed [nsol_pkg::VAL_W-1:0]    req_other_weight;
   logic                                 req_last;
   logic                                 empty;
   logic                                 pop;
   logic signed [nsol_pkg::SCORE_W-1:0]  rsp_score;
   logic                                 psel;
   logic                                 penable;
   logic                                 pwrite;
   logic [nsol_pkg::ADDR_W-1:0]          paddr;
   logic [nsol_pkg::DATA_W-1:0]          pwdata;
   logic [nsol_pkg::DATA_W-1:0]          prdata;
   logic                                 pready;

   // predictor state
   logic signed [nsol_pkg::SUM_W-1:0]    running_total;
   logic signed [nsol_pkg::VAL_W-1:0]    bias_setting;
   logic signed [nsol_pkg::SCORE_W-1:0]  expected_scores[$];

   int  fail_count;
   int  pop_stall;
   bit  steady;

   nnue_screlu_output_layer dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_white_value  (req_white_value),
      .req_black_value  (req_black_value),
      .req_side_to_move (req_side_to_move),
      .req_mover_weight (req_mover_weight),
      .req_other_weight (req_other_weight),
      .req_last         (req_last),
      .empty            (empty),
      .pop              (pop),
      .rsp_score        (rsp_score),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(5_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // clamp, cut the weighted value to its low half, square with the clamp again
   function automatic logic signed [nsol_pkg::SUM_W-1:0] screlu_term(
      logic signed [nsol_pkg::VAL_W-1:0] v, logic signed [nsol_pkg::VAL_W-1:0] w);
      int                                c;
      int                                p;
      logic signed [nsol_pkg::VAL_W-1:0] t;
      if (v < 0) c = 0;
      else if (v > nsol_pkg::QA) c = nsol_pkg::QA;
      else c = int'(v);
      p = c * int'(w);
      t = p[nsol_pkg::VAL_W-1:0];
      return int'(t) * c;
   endfunction

   task automatic predict_index(input acc_index_type it);
      logic signed [nsol_pkg::VAL_W-1:0] mover;
      logic signed [nsol_pkg::VAL_W-1:0] other;
      longint                            total;
      longint                            unsq;
      longint                            sc;
      mover = it.side_to_move ? it.black_value : it.white_value;
      other = it.side_to_move ? it.white_value : it.black_value;
      running_total = running_total + screlu_term(mover, it.mover_weight)
                                    + screlu_term(other, it.other_weight);
      if (it.last) begin
         total = longint'(running_total);
         unsq  = total / nsol_pkg::QA + longint'(bias_setting);
         sc    = unsq * nsol_pkg::SCALE / nsol_pkg::DIV2;
         if (sc > nsol_pkg::SCORE_MAX) sc = nsol_pkg::SCORE_MAX;
         if (sc < -nsol_pkg::SCORE_MAX) sc = -nsol_pkg::SCORE_MAX;
         expected_scores.push_back(nsol_pkg::SCORE_W'(sc));
         running_total = '0;
      end
   endtask

   task automatic send_index(input acc_index_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push             <= 1'b1;
      req_white_value  <= it.white_value;
      req_black_value  <= it.black_value;
      req_side_to_move <= it.side_to_move;
      req_mover_weight <= it.mover_weight;
      req_other_weight <= it.other_weight;
      req_last         <= it.last;
      do @(posedge clock); while (full);
      predict_index(it);
   endtask

   task automatic send_fields(input int wv, input int bv, input logic stm, input int mw,
                              input int ow, input logic is_last);
      acc_index_type it;
      it.white_value  = nsol_pkg::VAL_W'(wv);
      it.black_value  = nsol_pkg::VAL_W'(bv);
      it.side_to_move = stm;
      it.mover_weight = nsol_pkg::VAL_W'(mw);
      it.other_weight = nsol_pkg::VAL_W'(ow);
      it.last         = is_last;
      send_index(it);
   endtask

   // wait for every score, then let the back end settle
   task automatic drain();
      push <= 1'b0;
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_bias(input int value);
      logic signed [nsol_pkg::VAL_W-1:0] v;
      v = nsol_pkg::VAL_W'(value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= nsol_pkg::ADDR_W'(4 * nsol_pkg::REG_OUTPUT_BIAS);
      pwdata  <= {{(nsol_pkg::DATA_W-nsol_pkg::VAL_W){v[nsol_pkg::VAL_W-1]}}, v};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      bias_setting = v;
   endtask

   function automatic logic signed [nsol_pkg::VAL_W-1:0] random_value();
      if ($urandom_range(0, 3) == 0) return nsol_pkg::VAL_W'($urandom);
      return nsol_pkg::VAL_W'(int'($urandom_range(0, 141)) - 20);
   endfunction

   function automatic logic signed [nsol_pkg::VAL_W-1:0] random_weight();
      if ($urandom_range(0, 3) == 0)
         return nsol_pkg::VAL_W'(int'($urandom_range(0, 600)) - 300);
      return nsol_pkg::VAL_W'($urandom);
   endfunction

   task automatic report(input string what, input logic signed [nsol_pkg::SCORE_W-1:0] want,
                         input logic signed [nsol_pkg::SCORE_W-1:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s: expected score %0d, got %0d", $realtime, what, want, got);
   endtask

   // result side: random pop stalls, each popped score checked against the oldest expected score
   always @(posedge clock) begin
      if (reset) begin
         pop       <= 1'b0;
         pop_stall = 0;
      end else begin
         if (pop && !empty) begin
            if (expected_scores.size() == 0) report("unexpected result", '0, rsp_score);
            else if (rsp_score !== expected_scores[0]) begin
               report("score mismatch", expected_scores[0], rsp_score);
               void'(expected_scores.pop_front());
            end else begin
               void'(expected_scores.pop_front());
            end
         end
         if (pop_stall == 0 && $urandom_range(0, 7) == 0) pop_stall = pick_gap();
         if (pop_stall > 0) begin
            pop <= 1'b0;
            pop_stall--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   task automatic test_reset_bias();
      // scores are predicted with a zero bias straight after reset
      send_fields(50, 30, 1'b0, 1000, -700, 1'b1);
      send_fields(101, 101, 1'b1, 32767, 32767, 1'b0);
      send_fields(-5, 70, 1'b0, -1234, 222, 1'b1);
      drain();
   endtask

   task automatic test_field_extremes();
      int vals[8] = '{-32768, -1, 0, 1, 100, 101, 102, 32767};
      int wts[4]  = '{-32768, -1, 1, 32767};
      write_bias(32767);
      for (int i = 0; i < 8; i++)
         send_fields(vals[i], vals[7-i], i[0], wts[i%4], wts[(i+1)%4], i[0]);
      drain();
      write_bias(-32768);
      send_fields(32767, -32768, 1'b1, -32768, 32767, 1'b1);
      send_fields(101, 0, 1'b0, 1000, 0, 1'b1);
      drain();
      // small negative sums and scores truncate toward zero
      write_bias(-47);
      send_fields(1, 0, 1'b0, -50, 32767, 1'b1);
      send_fields(0, 1, 1'b1, 9, -50, 1'b1);
      drain();
   endtask

   task automatic test_score_saturation();
      // enough of the most negative term to clip at the bottom of the range
      write_bias(-32768);
      for (int i = 0; i < 66; i++)
         send_fields(32767, 101, i[1], -32768, -32768, i == 65);
      drain();
   endtask

   task automatic test_sum_wrap();
      // most negative term on both halves, long enough to wrap the 32-bit sum;
      // the wrapped sum is large and positive, so the score clips at the top
      write_bias(0);
      steady = 1'b1;
      for (int i = 0; i < 330; i++)
         send_fields(101, 101, i[0], -32768, -32768, i == 329);
      steady = 1'b0;
      drain();
   endtask

   task automatic test_random_sequences();
      acc_index_type it;
      int            sent;
      int            len;
      int            r;
      for (int phase = 0; phase < 5; phase++) begin
         write_bias(nsol_pkg::VAL_W'($urandom));
         steady = (phase == 2);
         sent = 0;
         while (sent < 8) begin
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(1, 4);
            else if (r < 95) len = $urandom_range(5, 10);
            else len = $urandom_range(11, 16);
            for (int k = 0; k < len; k++) begin
               it.white_value  = random_value();
               it.black_value  = random_value();
               it.side_to_move = 1'($urandom_range(0, 1));
               it.mover_weight = random_weight();
               it.other_weight = random_weight();
               it.last         = (k == len - 1);
               send_index(it);
            end
            sent += len;
         end
         steady = 1'b0;
         drain();
      end
   endtask

   initial begin
      reset            <= 1'b1;
      push             <= 1'b0;
      req_white_value  <= '0;
      req_black_value  <= '0;
      req_side_to_move <= 1'b0;
      req_mover_weight <= '0;
      req_other_weight <= '0;
      req_last         <= 1'b0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      running_total    = '0;
      bias_setting     = '0;
      fail_count       = 0;
      steady           = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_bias();
      test_field_extremes();
      test_score_saturation();
      test_sum_wrap();
      test_random_sequences();

      drain();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
